// ===== hdl/lpc_pkg.sv =====
// Package: shared types and constants of the LRU page cache with code lock.
package lpc_pkg;

    localparam int PAGE_W    = 8;
    localparam int SLOT_W    = 3;
    localparam int AGE_W     = 32;
    localparam int SLOTS_DEF = 8;

    localparam logic [AGE_W-1:0] AGE_LOCK  = 32'hFFFF_FFFF;
    localparam logic [AGE_W-1:0] COUNT_MAX = 32'hFFFF_FFFE;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_CODE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_MAIN = 2'd0,
        ST_SAME = 2'd1,
        ST_HIT  = 2'd2,
        ST_MISS = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode             opcode;
        logic [PAGE_W-1:0]   page;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [PAGE_W-1:0]   fill_page;
    } t_rsp;

    // One slot entry as kept in the slot memory.
    typedef struct packed {
        logic                used;
        logic [PAGE_W-1:0]   tag;
        logic [AGE_W-1:0]    age;
    } t_entry;

endpackage

// ===== hdl/lpc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lpc_ram #(
    parameter int W = 8,
    parameter int D = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                         i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lru_page_cache_with_code_lock_core.sv =====
// Top level: LRU page-slot manager with a locked code slot.
//
//   channel   signals                        direction  beat taken when
//   request   start, busy, i_req             in         start high and busy low
//   result    o_strobe, o_rsp                out        o_strobe high (one cycle)
//   config    i_cfg_we, i_cfg_wdata          in         i_cfg_we high
//
// A data request for a main-memory page, or a code change to the page that is
// already the code page, is answered in the cycle after the beat and busy stays low.
// Every other request scans the slot memory one entry per cycle, then decides,
// writes back, where needed, the old code slot and then the new slot, and presents
// its result in the cycle after the second write-back. The single read port of the
// slot memory is why the scan reads one entry at a time.
// Reset is synchronous and active low; it empties every slot through per-entry
// valid bits, so no clearing pass is needed. The receiver cannot stall results.
module lru_page_cache_with_code_lock_core #(
    parameter int SLOTS = lpc_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  lpc_pkg::t_req               i_req,
    output logic                        o_strobe,
    output lpc_pkg::t_rsp               o_rsp,
    input  logic                        i_cfg_we,
    input  logic [lpc_pkg::PAGE_W-1:0]  i_cfg_wdata
);

    import lpc_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = $bits(t_entry);

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_WOLD   = 5'b01000,
        S_WNEW   = 5'b10000
    } t_state;

    t_state r_state;

    // Architectural state kept in flip-flops.
    logic [PAGE_W-1:0] r_main_pages;
    logic [SLOTS-1:0]  r_valid;
    logic [AGE_W-1:0]  r_use;
    logic [IW-1:0]     r_cur;
    logic [IW-1:0]     r_code_slot;
    logic              r_code_in_main;
    logic [PAGE_W-1:0] r_code_page;
    logic              r_code_valid;

    // The request being worked on.
    t_opcode           r_op;
    logic [PAGE_W-1:0] r_page;
    logic              r_below;
    logic              r_sub;

    // Scan pipeline and the values it gathers.
    logic [CW-1:0]     r_cnt;
    logic              r_pvld;
    logic [IW-1:0]     r_pidx;
    logic [AGE_W-1:0]  r_least;
    logic [IW-1:0]     r_best;
    logic              r_found;
    logic [IW-1:0]     r_hit;
    logic              r_cur_hit;
    t_entry            r_code_ent;

    // Write-back requests prepared in the decide cycle.
    logic              r_wold_en;
    logic [IW-1:0]     r_wold_addr;
    t_entry            r_wold_data;
    logic              r_wnew_en;
    logic [IW-1:0]     r_wnew_addr;
    t_entry            r_wnew_data;

    logic              r_strobe;
    t_rsp              r_rsp;

    // Slot memory ports.
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic [EW-1:0]     ram_q;

    lpc_ram #(
        .W (EW),
        .D (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (ram_q)
    );

    assign ram_we    = ((r_state == S_WOLD) && r_wold_en) || ((r_state == S_WNEW) && r_wnew_en);
    assign ram_waddr = (r_state == S_WOLD) ? r_wold_addr : r_wnew_addr;
    assign ram_wdata = (r_state == S_WOLD) ? r_wold_data : r_wnew_data;

    // Entry coming back from the memory; a never-written entry reads as empty.
    t_entry           scan_ent;
    logic [AGE_W-1:0] scan_age;
    logic             scan_match;

    always_comb begin
        scan_ent = r_valid[r_pidx] ? t_entry'(ram_q) : '0;
        // On a code change the old code slot is first unlocked to the current count,
        // so the victim search sees that age instead of the lock.
        scan_age = (r_sub && (r_pidx == r_code_slot)) ? r_use : scan_ent.age;
        scan_match = scan_ent.used && (scan_ent.tag == r_page);
    end

    // Decision taken once the scan is complete.
    logic [AGE_W-1:0] cnt_inc;
    logic             is_code;
    logic             do_fetch;
    logic [IW-1:0]    new_idx;
    t_status          dec_status;
    logic             dec_wnew_en;
    logic             dec_wold_en;
    logic [IW+SLOT_W-1:0] new_ext;

    always_comb begin
        cnt_inc  = (r_use < COUNT_MAX) ? r_use + AGE_W'(1) : r_use;
        is_code  = (r_op == OP_CODE);
        // A code change to a main-memory page only moves the code out of its slot.
        do_fetch = !is_code || !r_below;
        new_idx  = r_cur_hit ? r_cur : (r_found ? r_hit : r_best);
        priority if (!do_fetch) begin
            dec_status = ST_MAIN;
        end else if (r_cur_hit) begin
            dec_status = ST_SAME;
        end else if (r_found) begin
            dec_status = ST_HIT;
        end else begin
            dec_status = ST_MISS;
        end
        // A data hit on the code page keeps the lock age; a hit on the current slot
        // changes nothing. A code change always locks its new slot.
        if (is_code) begin
            dec_wnew_en = do_fetch;
        end else begin
            dec_wnew_en = !r_cur_hit &&
                          !(r_found && r_code_valid && (r_code_page == r_page));
        end
        dec_wold_en = is_code && !r_code_in_main && !(do_fetch && (new_idx == r_code_slot));
        new_ext = {{SLOT_W{1'b0}}, new_idx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_main_pages   <= '0;
            r_valid        <= '0;
            r_use          <= '0;
            r_cur          <= '0;
            r_code_slot    <= '0;
            r_code_in_main <= 1'b0;
            r_code_page    <= '0;
            r_code_valid   <= 1'b0;
            r_strobe       <= 1'b0;
            r_pvld         <= 1'b0;
            r_cnt          <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_main_pages <= i_cfg_wdata;
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op       <= i_req.opcode;
                        r_page     <= i_req.page;
                        r_below    <= (i_req.page < r_main_pages);
                        r_sub      <= (i_req.opcode == OP_CODE) && !r_code_in_main;
                        r_cnt      <= '0;
                        r_pvld     <= 1'b0;
                        r_least    <= AGE_LOCK;
                        r_best     <= '0;
                        r_found    <= 1'b0;
                        r_hit      <= '0;
                        r_cur_hit  <= 1'b0;
                        r_code_ent <= '0;
                        priority if ((i_req.opcode == OP_DATA) &&
                                     (i_req.page < r_main_pages)) begin
                            r_rsp    <= '{status: ST_MAIN, slot: '0, fill_page: '0};
                            r_strobe <= 1'b1;
                        end else if ((i_req.opcode == OP_CODE) && r_code_valid &&
                                     (r_code_page == i_req.page)) begin
                            r_rsp.status    <= ST_SAME;
                            r_rsp.slot      <= r_code_in_main ? '0 :
                                SLOT_W'({{SLOT_W{1'b0}}, r_code_slot});
                            r_rsp.fill_page <= '0;
                            r_strobe        <= 1'b1;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cnt < CW'(SLOTS)) begin
                        r_cnt  <= r_cnt + CW'(1);
                        r_pvld <= 1'b1;
                        r_pidx <= r_cnt[IW-1:0];
                    end else begin
                        r_pvld <= 1'b0;
                    end
                    if (r_pvld) begin
                        if (scan_age < r_least) begin
                            r_least <= scan_age;
                            r_best  <= r_pidx;
                        end
                        if (scan_match && !r_found) begin
                            r_found <= 1'b1;
                            r_hit   <= r_pidx;
                        end
                        if (r_pidx == r_cur) begin
                            r_cur_hit <= scan_match;
                        end
                        if (r_pidx == r_code_slot) begin
                            r_code_ent <= scan_ent;
                        end
                        if (r_cnt == CW'(SLOTS)) begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_DECIDE: begin
                    r_wold_en   <= dec_wold_en;
                    r_wold_addr <= r_code_slot;
                    r_wold_data <= '{used: r_code_ent.used, tag: r_code_ent.tag, age: r_use};
                    r_wnew_en   <= dec_wnew_en;
                    r_wnew_addr <= new_idx;
                    r_wnew_data <= '{used: 1'b1, tag: r_page,
                                     age: is_code ? AGE_LOCK : cnt_inc};
                    if (do_fetch) begin
                        r_cur <= new_idx;
                        if (!r_cur_hit) begin
                            r_use <= cnt_inc;
                        end
                    end
                    if (is_code) begin
                        r_code_page    <= r_page;
                        r_code_valid   <= 1'b1;
                        r_code_in_main <= !do_fetch;
                        if (do_fetch) begin
                            r_code_slot <= new_idx;
                        end
                    end
                    r_rsp.status    <= dec_status;
                    r_rsp.slot      <= do_fetch ? new_ext[SLOT_W-1:0] : '0;
                    r_rsp.fill_page <= (dec_status == ST_MISS) ? r_page : '0;
                    r_state         <= S_WOLD;
                end
                S_WOLD: begin
                    r_state <= S_WNEW;
                end
                S_WNEW: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule
